/* design/sequential_list_engine_assert.svh */
// assertion macros shared by the list engine modules
`ifndef SEQUENTIAL_LIST_ENGINE_ASSERT_SVH
`define SEQUENTIAL_LIST_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define SLE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SLE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SLE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define SLE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

/* design/sle_pkg.sv */
`default_nettype none

package sle_pkg;

    typedef enum logic [1:0] {
        FUNC_READ   = 2'd0,
        FUNC_FIND   = 2'd1,
        FUNC_INSERT = 2'd2,
        FUNC_DELETE = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    localparam int unsigned POS_W = 11;
    localparam int unsigned VAL_W = 32;

    typedef struct packed {
        func_t                    func;
        logic [POS_W-1:0]         position;
        logic signed [VAL_W-1:0]  value;
    } sle_req_t;

    typedef struct packed {
        status_t                  status;
        logic [POS_W-1:0]         found_position;
        logic signed [VAL_W-1:0]  read_value;
        logic [POS_W-1:0]         current_length;
    } sle_rsp_t;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic step;
        logic finish;
    } sle_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic walk_done;
        logic out_busy;
    } sle_sts_t;

endpackage

`default_nettype wire

/* design/sle_ctrl.sv */
`default_nettype none

`include "sequential_list_engine_assert.svh"

module sle_ctrl
    import sle_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire sle_sts_t sts,
    output sle_cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                cmd.step = 1'b1;
                if (sts.walk_done) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                // wait for the output register to free up
                if (!sts.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `SLE_ASSERT_NXT(a_start_walk, aclk, aresetn, cmd.start, state_reg == S_WALK, "start did not enter walk")
    `SLE_ASSERT_IMP(a_finish_free, aclk, aresetn, cmd.finish, !sts.out_busy, "finish while output held")
    `SLE_ASSERT_IMP(a_ready_idle, aclk, aresetn, s_ready, state_reg == S_IDLE, "ready outside idle")

endmodule

`default_nettype wire

/* design/sle_datapath.sv */
`default_nettype none

`include "sequential_list_engine_assert.svh"

module sle_datapath
    import sle_pkg::*;
#(
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire sle_cmd_t cmd,
    output sle_sts_t      sts,
    input  wire sle_req_t s_req,
    output logic          m_valid,
    input  wire logic     m_ready,
    output sle_rsp_t      m_rsp
);

    localparam int unsigned AW   = $clog2(DEPTH);
    localparam int unsigned CW   = $clog2(DEPTH + 1);
    localparam int unsigned CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

    logic signed [VAL_W-1:0] mem [DEPTH];
    logic signed [VAL_W-1:0] mem_q_reg;

    sle_req_t       req_reg;
    status_t        err_reg;
    logic [AW-1:0]  at_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic [CW-1:0]  rem_reg;
    logic [CW-1:0]  ptr_reg;
    logic           pend_reg;
    logic [AW-1:0]  pend_addr_reg;
    logic           found_reg;
    logic [CW-1:0]  found_pos_reg;
    logic           m_valid_reg;
    sle_rsp_t       rsp_reg;

    // request decode at accept
    logic [CMPW-1:0] pos_w;
    logic [CMPW-1:0] cnt_w;
    logic [CMPW-1:0] rem_init;
    logic [CMPW-1:0] ptr_init;
    status_t         err_start;

    always_comb begin
        pos_w     = CMPW'(s_req.position);
        cnt_w     = CMPW'(count_reg);
        err_start = STATUS_OK;
        rem_init  = '0;
        ptr_init  = '0;
        unique case (s_req.func)
            FUNC_READ: begin
                if (pos_w == '0 || pos_w > cnt_w) begin
                    err_start = STATUS_RANGE;
                end else begin
                    rem_init = CMPW'(1);
                    ptr_init = pos_w - CMPW'(1);
                end
            end
            FUNC_FIND: begin
                rem_init = cnt_w;
            end
            FUNC_INSERT: begin
                if (pos_w == '0 || pos_w > cnt_w + CMPW'(1)) begin
                    err_start = STATUS_RANGE;
                end else if (count_reg == CW'(DEPTH)) begin
                    err_start = STATUS_FULL;
                end else begin
                    // move entries at..count-1 up by one, highest first
                    rem_init = cnt_w - pos_w + CMPW'(1);
                    ptr_init = cnt_w - CMPW'(1);
                end
            end
            FUNC_DELETE: begin
                if (pos_w == '0 || pos_w > cnt_w) begin
                    err_start = STATUS_RANGE;
                end else begin
                    // move entries pos..count-1 down by one, lowest first
                    rem_init = cnt_w - pos_w;
                    ptr_init = pos_w;
                end
            end
            default: begin
                err_start = STATUS_OK;
            end
        endcase
    end

    // walk: one memory read issued and one earlier read consumed per cycle
    logic                    issue;
    logic                    consume;
    logic                    rd_en;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic signed [VAL_W-1:0] wr_data;
    logic                    hit;
    logic                    ok_done;

    assign issue   = cmd.step && (rem_reg != '0) && !found_reg;
    assign consume = cmd.step && pend_reg;
    assign rd_en   = issue;
    assign hit     = consume && (req_reg.func == FUNC_FIND) && !found_reg
                     && (mem_q_reg == req_reg.value);
    assign ok_done = cmd.finish && (err_reg == STATUS_OK);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = pend_addr_reg;
        wr_data = mem_q_reg;
        if (ok_done && req_reg.func == FUNC_INSERT) begin
            wr_en   = 1'b1;
            wr_addr = at_reg;
            wr_data = req_reg.value;
        end else if (consume && req_reg.func == FUNC_INSERT) begin
            wr_en   = 1'b1;
            wr_addr = pend_addr_reg + AW'(1);
        end else if (consume && req_reg.func == FUNC_DELETE) begin
            wr_en   = 1'b1;
            wr_addr = pend_addr_reg - AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            mem_q_reg <= mem[ptr_reg[AW-1:0]];
        end
    end

    always_comb begin
        count_next = count_reg;
        if (ok_done && req_reg.func == FUNC_INSERT) begin
            count_next = count_reg + CW'(1);
        end else if (ok_done && req_reg.func == FUNC_DELETE) begin
            count_next = count_reg - CW'(1);
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            rem_reg     <= '0;
            ptr_reg     <= '0;
            pend_reg    <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (cmd.start) begin
                rem_reg   <= CW'(rem_init);
                ptr_reg   <= CW'(ptr_init);
                pend_reg  <= 1'b0;
                found_reg <= 1'b0;
            end else begin
                pend_reg <= issue;
                if (issue) begin
                    rem_reg <= rem_reg - CW'(1);
                    if (req_reg.func == FUNC_INSERT) begin
                        ptr_reg <= ptr_reg - CW'(1);
                    end else begin
                        ptr_reg <= ptr_reg + CW'(1);
                    end
                end
                if (hit) begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            req_reg <= s_req;
            err_reg <= err_start;
            at_reg  <= AW'(pos_w - CMPW'(1));
        end
        if (issue) begin
            pend_addr_reg <= ptr_reg[AW-1:0];
        end
        if (hit) begin
            found_pos_reg <= CW'(pend_addr_reg) + CW'(1);
        end
        if (cmd.finish) begin
            rsp_reg.status         <= err_reg;
            rsp_reg.found_position <= (req_reg.func == FUNC_FIND && found_reg)
                                      ? POS_W'(found_pos_reg) : '0;
            rsp_reg.read_value     <= (req_reg.func == FUNC_READ && err_reg == STATUS_OK)
                                      ? mem_q_reg : '0;
            rsp_reg.current_length <= POS_W'(count_next);
        end
    end

    assign sts.walk_done = ((rem_reg == '0) && !pend_reg) || found_reg;
    assign sts.out_busy  = m_valid_reg && !m_ready;
    assign m_valid       = m_valid_reg;
    assign m_rsp         = rsp_reg;

    `SLE_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(DEPTH), "count above depth")
    `SLE_ASSERT_IMP(a_no_rw_clash, aclk, aresetn, wr_en && rd_en, wr_addr != ptr_reg[AW-1:0], "read and write hit one entry")
    `SLE_ASSERT_NXT(a_found_stops, aclk, aresetn, found_reg && cmd.step, !pend_reg, "walk went on after a match")

endmodule

`default_nettype wire

/* design/sequential_list_engine.sv */
`default_nettype none

// bounded ordered list of signed 32-bit words held in a single on-chip memory of DEPTH
// entries, with a current length. each request reads the word at a 1-based position,
// finds the first position holding a value (0 when absent), inserts a value at a position
// (later entries move up) or deletes at a position (later entries move down), and returns
// exactly one result carrying status, found position, read word and the new length.
// a bad position returns status 1 and an insert into a full list returns status 2; neither
// changes the list. one request is handled at a time: the sequencer walks memory, hands the
// result to the output register and only then returns to idle to take the next request.
// the memory walk touches 1 entry for a read, at most the current length for a find (it
// stops once the first match is seen), length - position + 1 for an insert and
// length - position for a delete. the memory port reads one entry and writes one entry per
// cycle. the next request is taken while a finished result still waits in the output
// register. no clearing pass runs after reset; only entries below the current length are
// ever read.

module sequential_list_engine
    import sle_pkg::*;
#(
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    // request channel
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire sle_req_t s_req,
    // result channel
    output logic          m_valid,
    input  wire logic     m_ready,
    output sle_rsp_t      m_rsp
);

    // command and status between sequencer and datapath
    sle_cmd_t cmd;
    sle_sts_t sts;

    // sequencer: idle, memory walk, result hand-off
    sle_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // datapath: list memory, length, walk pointers, output register
    sle_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import sle_pkg::*;

    localparam int unsigned LIST_DEPTH  = 1024;
    localparam int unsigned CYCLE_LIMIT = 8_000_000;
    // longest walk touches DEPTH entries
    localparam int unsigned DRAIN_WAIT  = LIST_DEPTH + 64;

    // one row of the directed table; rsp only used when typed is set
    typedef struct packed {
        sle_req_t req;
        logic     typed;
        sle_rsp_t rsp;
    } dir_row_t;

    logic     aclk = 1'b0;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    sle_req_t s_req;
    logic     m_valid;
    logic     m_ready;
    sle_rsp_t m_rsp;

    // shadow copy of the list contents, position 1 at index 0
    logic signed [VAL_W-1:0] shadow_list[$];
    // responses still owed by the engine, oldest first
    sle_rsp_t                rsp_due_q[$];
    dir_row_t                directed_rows[$];

    int unsigned errors      = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left  = 0;

    sequential_list_engine #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // apply one request to the shadow list and return the response it owes
    function automatic sle_rsp_t apply_list_op(sle_req_t r);
        sle_rsp_t    rsp;
        int unsigned pos;
        int unsigned len;
        rsp = '0;
        rsp.status = STATUS_OK;
        pos = 32'(r.position);
        len = shadow_list.size();
        case (r.func)
            FUNC_READ: begin
                if (pos == 0 || pos > len)
                    rsp.status = STATUS_RANGE;
                else
                    rsp.read_value = shadow_list[pos - 1];
            end
            FUNC_FIND: begin
                // first match only, search stops once found_position is set
                for (int k = 0; k < len && rsp.found_position == 0; k++) begin
                    if (shadow_list[k] == r.value)
                        rsp.found_position = POS_W'(k + 1);
                end
            end
            FUNC_INSERT: begin
                // position check wins over the full check
                if (pos == 0 || pos > len + 1)
                    rsp.status = STATUS_RANGE;
                else if (len >= LIST_DEPTH)
                    rsp.status = STATUS_FULL;
                else
                    shadow_list.insert(pos - 1, r.value);
            end
            FUNC_DELETE: begin
                if (pos == 0 || pos > len)
                    rsp.status = STATUS_RANGE;
                else
                    shadow_list.delete(pos - 1);
            end
        endcase
        rsp.current_length = POS_W'(shadow_list.size());
        return rsp;
    endfunction

    // random request; len_goal steers the insert/delete balance
    function automatic sle_req_t random_request(int unsigned len_goal);
        sle_req_t    r;
        int unsigned len;
        int unsigned sel;
        r = '0;
        len = shadow_list.size();
        sel = $urandom_range(0, 99);
        if (sel < 20)
            r.func = FUNC_READ;
        else if (sel < 35)
            r.func = FUNC_FIND;
        else if (sel < ((len < len_goal) ? 75 : 55))
            r.func = FUNC_INSERT;
        else
            r.func = FUNC_DELETE;

        // mostly near-valid positions, with edges and full-range noise
        case ($urandom_range(0, 9))
            0: r.position = POS_W'($urandom_range(0, 2047));
            1: r.position = '0;
            2: r.position = POS_W'(len + 1);
            3: r.position = POS_W'(len);
            default: r.position = POS_W'($urandom_range(1, len + 1));
        endcase

        // values already in the list make finds hit and create duplicates
        case ($urandom_range(0, 7))
            0, 1, 2: begin
                if (len != 0)
                    r.value = shadow_list[$urandom_range(0, len - 1)];
                else
                    r.value = $urandom();
            end
            3: r.value = 32'($urandom_range(0, 7)) - 32'd4;
            4: r.value = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: r.value = $urandom();
        endcase
        return r;
    endfunction

    function automatic dir_row_t dir_row(func_t f, int unsigned pos, logic [31:0] val,
                                         int unsigned typed, status_t st, int unsigned fnd,
                                         logic [31:0] rd, int unsigned len);
        dir_row_t d;
        d.req.func           = f;
        d.req.position       = POS_W'(pos);
        d.req.value          = val;
        d.typed              = (typed != 0);
        d.rsp.status         = st;
        d.rsp.found_position = POS_W'(fnd);
        d.rsp.read_value     = rd;
        d.rsp.current_length = POS_W'(len);
        return d;
    endfunction

    // drive one request starting at a falling edge; returns at the falling edge
    // after the accept. bursts of back-to-back requests, random gaps between them
    task automatic issue(input sle_req_t r, input logic typed, input sle_rsp_t typed_rsp);
        sle_rsp_t due;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 16);
        end
        burst_left--;
        s_req   <= r;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // accepted at this edge: advance the shadow list
        due = apply_list_op(r);
        rsp_due_q.push_back(typed ? typed_rsp : due);
        @(negedge aclk);
    endtask

    // hold off the request side until every owed response is back
    task automatic drain_responses();
        s_valid <= 1'b0;
        do @(negedge aclk); while (rsp_due_q.size() != 0);
    endtask

    // result side: random runs of m_ready low; the stall rate is redrawn from 0, 10 and 40 percent on a tick counter
    initial begin : result_side
        int unsigned stall_left;
        int unsigned stall_pct;
        int unsigned tick;
        stall_left = 0;
        stall_pct  = 0;
        tick       = 0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            tick++;
            if (tick % 256 == 0) begin
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    default: stall_pct = 40;
                endcase
            end
            if (stall_left != 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 99) < stall_pct)
                    stall_left = $urandom_range(1, 8);
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // response checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (rsp_due_q.size() == 0) begin
                $display("%0t: response with none owed: expected nothing, got %p",
                         $time, m_rsp);
                errors++;
            end else begin
                check_field("status", 32'(rsp_due_q[0].status), 32'(m_rsp.status));
                check_field("found_position", 32'(rsp_due_q[0].found_position),
                            32'(m_rsp.found_position));
                check_field("read_value", rsp_due_q[0].read_value, m_rsp.read_value);
                check_field("current_length", 32'(rsp_due_q[0].current_length),
                            32'(m_rsp.current_length));
                void'(rsp_due_q.pop_front());
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[sequential_list_engine] ERROR");
            $finish;
        end
    end

    initial begin : request_side
        int unsigned len_goal;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_req   = '0;

        // directed table, starts from the empty list
        // empty list: everything out of range, find misses
        directed_rows.push_back(dir_row(FUNC_READ,   1, 0, 1, STATUS_RANGE, 0, 0, 0));
        directed_rows.push_back(dir_row(FUNC_DELETE, 1, 0, 1, STATUS_RANGE, 0, 0, 0));
        directed_rows.push_back(dir_row(FUNC_FIND,   0, 0, 1, STATUS_OK,    0, 0, 0));
        directed_rows.push_back(dir_row(FUNC_INSERT, 0, 5, 1, STATUS_RANGE, 0, 0, 0));
        directed_rows.push_back(dir_row(FUNC_INSERT, 2, 5, 1, STATUS_RANGE, 0, 0, 0));
        // build [-1, min, max]
        directed_rows.push_back(dir_row(FUNC_INSERT, 1, 32'h8000_0000, 1, STATUS_OK,
                                        0, 0, 1));
        directed_rows.push_back(dir_row(FUNC_INSERT, 2, 32'h7FFF_FFFF, 1, STATUS_OK,
                                        0, 0, 2));
        directed_rows.push_back(dir_row(FUNC_INSERT, 1, 32'hFFFF_FFFF, 1, STATUS_OK,
                                        0, 0, 3));
        // reads at both ends and just past them
        directed_rows.push_back(dir_row(FUNC_READ, 1, 0, 1, STATUS_OK, 0, 32'hFFFF_FFFF, 3));
        directed_rows.push_back(dir_row(FUNC_READ, 3, 0, 1, STATUS_OK, 0, 32'h7FFF_FFFF, 3));
        directed_rows.push_back(dir_row(FUNC_READ, 4, 0, 1, STATUS_RANGE, 0, 0, 3));
        directed_rows.push_back(dir_row(FUNC_READ, 0, 0, 1, STATUS_RANGE, 0, 0, 3));
        // finds: last entry, middle entry, absent value
        directed_rows.push_back(dir_row(FUNC_FIND, 0, 32'h7FFF_FFFF, 1, STATUS_OK, 3, 0, 3));
        directed_rows.push_back(dir_row(FUNC_FIND, 0, 32'h8000_0000, 1, STATUS_OK, 2, 0, 3));
        directed_rows.push_back(dir_row(FUNC_FIND, 0, 0, 1, STATUS_OK, 0, 0, 3));
        // middle insert and append of a duplicate: [-1, 0, min, max, -1]
        directed_rows.push_back(dir_row(FUNC_INSERT, 2, 0, 1, STATUS_OK, 0, 0, 4));
        directed_rows.push_back(dir_row(FUNC_INSERT, 5, 32'hFFFF_FFFF, 1, STATUS_OK,
                                        0, 0, 5));
        // duplicate: first match wins
        directed_rows.push_back(dir_row(FUNC_FIND, 0, 32'hFFFF_FFFF, 1, STATUS_OK, 1, 0, 5));
        // all-ones position and other bad positions
        directed_rows.push_back(dir_row(FUNC_INSERT, 2047, 1, 1, STATUS_RANGE, 0, 0, 5));
        directed_rows.push_back(dir_row(FUNC_DELETE, 2047, 0, 1, STATUS_RANGE, 0, 0, 5));
        directed_rows.push_back(dir_row(FUNC_DELETE, 0, 0, 1, STATUS_RANGE, 0, 0, 5));
        directed_rows.push_back(dir_row(FUNC_DELETE, 6, 0, 1, STATUS_RANGE, 0, 0, 5));
        // shifting cases go through the shadow list
        directed_rows.push_back(dir_row(FUNC_DELETE, 1, 0, 0, STATUS_OK, 0, 0, 0));
        directed_rows.push_back(dir_row(FUNC_FIND, 0, 32'hFFFF_FFFF, 0, STATUS_OK, 0, 0, 0));
        directed_rows.push_back(dir_row(FUNC_INSERT, 5, 32'h1234_5678, 0, STATUS_OK,
                                        0, 0, 0));
        directed_rows.push_back(dir_row(FUNC_DELETE, 5, 0, 0, STATUS_OK, 0, 0, 0));

        // synchronous reset, released at a falling edge
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i])
            issue(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);

        // random traffic on short lists, target length changes every 50 requests
        len_goal = 4;
        for (int n = 0; n < 300; n++) begin
            if (n % 50 == 0) begin
                case ($urandom_range(0, 2))
                    0: len_goal = 4;
                    1: len_goal = 16;
                    default: len_goal = 48;
                endcase
            end
            issue(random_request(len_goal), 1'b0, '0);
        end

        // let the engine run dry, then go on from where the list stands
        drain_responses();

        for (int n = 0; n < 74; n++)
            issue(random_request(len_goal), 1'b0, '0);

        // wait for the last responses, then watch for strays
        drain_responses();
        repeat (DRAIN_WAIT) @(negedge aclk);

        if (errors == 0)
            $display("[sequential_list_engine] OK");
        else
            $display("[sequential_list_engine] ERROR");
        $finish;
    end

endmodule

/* sequential_list_engine.f */
+incdir+design
design/sle_pkg.sv
design/sle_ctrl.sv
design/sle_datapath.sv
design/sequential_list_engine.sv
tb/testbench.sv
